### rtl/core/fbpfc_pkg.sv
// Package for the framebuffer pixel format converter.
// Field widths, format and register codes, and shared types. No dependencies.
package fbpfc_pkg;

    localparam int POS_W    = 10;
    localparam int CHAN_W   = 8;
    localparam int WORD_W   = 32;
    localparam int FMT_W    = 3;
    localparam int STRIDE_W = 16;
    localparam int BYTES_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_SCREEN_HEIGHT = 240;

    // format codes; anything else is RGB565
    localparam logic [FMT_W-1:0] FMT_BGRA8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_BGR8   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB5A1 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGBA4  = 3'd4;

    localparam logic OP_PACK   = 1'b0;
    localparam logic OP_UNPACK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd2;

    typedef struct packed {
        logic [FMT_W-1:0]    fmt;
        logic [STRIDE_W-1:0] stride;
        logic [WORD_W-1:0]   base;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [WORD_W-1:0] word;
    } t_pix;

    function automatic logic [BYTES_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
        logic [BYTES_W-1:0] bpp;
        case (fmt)
            FMT_BGRA8: bpp = 3'd4;
            FMT_BGR8:  bpp = 3'd3;
            default:   bpp = 3'd2;
        endcase
        return bpp;
    endfunction

endpackage

### rtl/core/fbpfc_addr.sv
// Address path: base + x*stride + (height-1-y)*bpp, bit 31 set; all zero when base is zero.
// Two register stages. Depends on fbpfc_pkg.
module fbpfc_addr #(
    parameter int SCREEN_HEIGHT = fbpfc_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                           i_clk,
    input  fbpfc_pkg::t_cfg                i_cfg,
    input  logic [fbpfc_pkg::POS_W-1:0]    i_pos_x,
    input  logic [fbpfc_pkg::POS_W-1:0]    i_pos_y,
    output logic [fbpfc_pkg::WORD_W-1:0]   o_pixel_address,
    output logic [fbpfc_pkg::BYTES_W-1:0]  o_access_bytes
);
    import fbpfc_pkg::*;

    localparam int PROD_W = POS_W + STRIDE_W;
    localparam logic [WORD_W-1:0] ROW_TOP = WORD_W'(SCREEN_HEIGHT - 1);

    logic [PROD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_row_term;
    logic [WORD_W-1:0]  r_addr;
    logic [BYTES_W-1:0] r_bytes;

    logic [WORD_W-1:0]  row;
    logic [BYTES_W-1:0] bpp;
    logic [WORD_W-1:0]  n_addr;

    assign bpp    = bytes_per_pixel(i_cfg.fmt);
    // row wraps mod 2^32 when y is past the screen
    assign row    = ROW_TOP - WORD_W'(i_pos_y);
    assign n_addr = (i_cfg.base + WORD_W'(r_prod) + r_row_term) | {1'b1, {(WORD_W-1){1'b0}}};

    always_ff @(posedge i_clk) begin
        r_prod     <= PROD_W'(i_pos_x) * PROD_W'(i_cfg.stride);
        r_row_term <= row * WORD_W'(bpp);
        if (i_cfg.base == '0) begin
            r_addr  <= '0;
            r_bytes <= '0;
        end else begin
            r_addr  <= n_addr;
            r_bytes <= bpp;
        end
    end

    assign o_pixel_address = r_addr;
    assign o_access_bytes  = r_bytes;

endmodule

### rtl/core/fbpfc_pixel.sv
// Pixel path: packs RGB888 into a framebuffer word or expands one back.
// Two register stages. Depends on fbpfc_pkg.
module fbpfc_pixel (
    input  logic                          i_clk,
    input  fbpfc_pkg::t_cfg               i_cfg,
    input  fbpfc_pkg::t_pix               i_pix,
    output logic [fbpfc_pkg::WORD_W-1:0]  o_write_word,
    output logic [fbpfc_pkg::CHAN_W-1:0]  o_out_red,
    output logic [fbpfc_pkg::CHAN_W-1:0]  o_out_green,
    output logic [fbpfc_pkg::CHAN_W-1:0]  o_out_blue
);
    import fbpfc_pkg::*;

    t_pix              r_pix;
    logic [WORD_W-1:0] r_wword;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    logic [WORD_W-1:0] packed_word;
    logic [CHAN_W-1:0] n_red, n_green, n_blue;
    logic [15:0]       v;

    assign v = r_pix.word[15:0];

    always_comb begin
        case (i_cfg.fmt)
            FMT_BGRA8: packed_word = {8'hFF, r_pix.red, r_pix.green, r_pix.blue};
            FMT_BGR8:  packed_word = {8'h00, r_pix.red, r_pix.green, r_pix.blue};
            FMT_RGB5A1: packed_word = {16'h0, r_pix.red[7:3], r_pix.green[7:3],
                                       r_pix.blue[7:3], 1'b1};
            FMT_RGBA4: packed_word = {16'h0, r_pix.red[7:4], r_pix.green[7:4],
                                      r_pix.blue[7:4], 4'hF};
            default:   packed_word = {16'h0, r_pix.red[7:3], r_pix.green[7:2],
                                      r_pix.blue[7:3]};
        endcase
    end

    always_comb begin
        case (i_cfg.fmt)
            FMT_BGRA8, FMT_BGR8: begin
                n_red   = r_pix.word[23:16];
                n_green = r_pix.word[15:8];
                n_blue  = r_pix.word[7:0];
            end
            FMT_RGB5A1: begin
                n_red   = {v[15:11], 3'b000};
                n_green = {v[10:6], 3'b000};
                n_blue  = {v[5:1], 3'b000};
            end
            FMT_RGBA4: begin
                // nibble * 17 is the nibble repeated
                n_red   = {v[15:12], v[15:12]};
                n_green = {v[11:8], v[11:8]};
                n_blue  = {v[7:4], v[7:4]};
            end
            default: begin
                n_red   = {v[15:11], 3'b000};
                n_green = {v[10:5], 2'b00};
                n_blue  = {v[4:0], 3'b000};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pix   <= i_pix;
        r_wword <= '0;
        r_red   <= '0;
        r_green <= '0;
        r_blue  <= '0;
        if (i_cfg.base != '0) begin
            if (r_pix.op == OP_PACK) begin
                r_wword <= packed_word;
            end else begin
                r_red   <= n_red;
                r_green <= n_green;
                r_blue  <= n_blue;
            end
        end
    end

    assign o_write_word = r_wword;
    assign o_out_red    = r_red;
    assign o_out_green  = r_green;
    assign o_out_blue   = r_blue;

endmodule

### rtl/core/framebuffer_pixel_format_converter.sv
// Top level of the framebuffer pixel format converter.
// Holds the configuration registers and the item valid pipeline.
// Depends on fbpfc_pkg, fbpfc_addr, fbpfc_pixel.
//
// Usage:
//   Configuration: write pixel_format (0), column_stride (1) and frame_base (2)
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
//   Index 3 is ignored.
//   Items: drive the payload ports and raise i_start; o_busy is always low,
//   so an item is taken on every cycle i_start is high.
//   Results: o_done pulses for one cycle once the item has passed r_v1 and r_v2,
//   with the address, byte count and packed word or expanded RGB.
//   Throughput is one item per cycle: stage 1 holds the x*stride product and
//   row term plus the captured pixel, stage 2 the sum and the packed/unpacked
//   pixel.
//   frame_base of zero gives an all-zero result; a pack gives zero RGB and an
//   unpack a zero write word.
//   Reset clears the configuration registers and the valid pipeline; items in
//   flight are dropped.
//   The receiver cannot stall: each result is shown for exactly one cycle.
module framebuffer_pixel_format_converter #(
    parameter int SCREEN_HEIGHT = fbpfc_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbpfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fbpfc_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_opcode,
    input  logic [fbpfc_pkg::POS_W-1:0]     i_pos_x,
    input  logic [fbpfc_pkg::POS_W-1:0]     i_pos_y,
    input  logic [fbpfc_pkg::CHAN_W-1:0]    i_in_red,
    input  logic [fbpfc_pkg::CHAN_W-1:0]    i_in_green,
    input  logic [fbpfc_pkg::CHAN_W-1:0]    i_in_blue,
    input  logic [fbpfc_pkg::WORD_W-1:0]    i_read_word,
    output logic                            o_done,
    output logic [fbpfc_pkg::WORD_W-1:0]    o_pixel_address,
    output logic [fbpfc_pkg::BYTES_W-1:0]   o_access_bytes,
    output logic [fbpfc_pkg::WORD_W-1:0]    o_write_word,
    output logic [fbpfc_pkg::CHAN_W-1:0]    o_out_red,
    output logic [fbpfc_pkg::CHAN_W-1:0]    o_out_green,
    output logic [fbpfc_pkg::CHAN_W-1:0]    o_out_blue
);
    import fbpfc_pkg::*;

    t_cfg r_cfg;
    logic r_v1;
    logic r_v2;
    t_pix pix;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FORMAT: r_cfg.fmt    <= i_cfg_data[FMT_W-1:0];
                CFG_STRIDE: r_cfg.stride <= i_cfg_data[STRIDE_W-1:0];
                CFG_BASE:   r_cfg.base   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid tracks the two data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign pix.op    = i_opcode;
    assign pix.red   = i_in_red;
    assign pix.green = i_in_green;
    assign pix.blue  = i_in_blue;
    assign pix.word  = i_read_word;

    fbpfc_addr #(
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_addr (
        .i_clk           (i_clk),
        .i_cfg           (r_cfg),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .o_pixel_address (o_pixel_address),
        .o_access_bytes  (o_access_bytes)
    );

    fbpfc_pixel u_pixel (
        .i_clk        (i_clk),
        .i_cfg        (r_cfg),
        .i_pix        (pix),
        .o_write_word (o_write_word),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue)
    );

    assign o_busy = 1'b0;
    assign o_done = r_v2;

endmodule
